// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/ccab_pkg.sv -----
// Shared types, codes and constants of the CSMA-CA backoff controller.
package ccab_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  // Request opcodes
  localparam logic [1:0] OP_SUBMIT   = 2'd0;
  localparam logic [1:0] OP_COMPLETE = 2'd1;
  localparam logic [1:0] OP_BUSY     = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_WAIT = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;
  localparam logic [1:0] KIND_DROP = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CSMA_EN   = 2'd0;
  localparam logic [1:0] CFG_MIN_EXP   = 2'd1;
  localparam logic [1:0] CFG_MAX_EXP   = 2'd2;
  localparam logic [1:0] CFG_UNIT_TIME = 2'd3;

  // Register reset values
  localparam logic        CSMA_EN_RST   = 1'b1;
  localparam logic [3:0]  MIN_EXP_RST   = 4'd3;
  localparam logic [3:0]  MAX_EXP_RST   = 4'd5;
  localparam logic [15:0] UNIT_TIME_RST = 16'd320;

  // Waits at or below this are reported as zero
  localparam logic [15:0] SHORT_WAIT_LIMIT = 16'd10;

  // (2^15 - 1) * 65535 needs 31 bits
  localparam int INTERVAL_W = 31;
  // Remainder unit: one dividend bit per step, sixteen steps
  localparam logic [3:0] DIV_CNT_LAST = 4'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PASS,
    ST_DROP,
    ST_START,
    ST_FAIL,
    ST_RETIRE,
    ST_READ,
    ST_NEXT,
    ST_DIV,
    ST_WAIT,
    ST_RETX
  } state_t;

  typedef enum logic [2:0] {
    EM_PASS,
    EM_DROP,
    EM_START,
    EM_NEXT,
    EM_FAIL,
    EM_WAIT,
    EM_RETX
  } emit_t;

  typedef struct packed {
    logic  capture;
    logic  push;
    logic  raise;
    logic  retire;
    logic  div_step;
    logic  emit;
    emit_t emit_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       csma_en;
    logic       tx_active;
    logic       full;
    logic       raise_fail;
    logic       more_queued;
    logic       div_last;
    logic       out_free;
  } status_t;

endpackage

// ----- rtl/ccab_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ccab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ccab_ctrl.sv -----
// Sequencing state machine of the CSMA-CA backoff controller.
module ccab_ctrl
  import ccab_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t status,
  output logic    in_stall,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   active_ok;

  assign active_ok = status.csma_en && status.tx_active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        if (status.op == OP_SUBMIT) begin
          if (!status.csma_en)        state_nxt = ST_PASS;
          else if (status.full)       state_nxt = ST_DROP;
          else if (!status.tx_active) state_nxt = ST_START;
        end else if (status.op == OP_COMPLETE && active_ok) begin
          state_nxt = ST_RETIRE;
        end else if (status.op == OP_BUSY && active_ok) begin
          state_nxt = status.raise_fail ? ST_FAIL : ST_DIV;
        end
      end
      ST_PASS, ST_DROP, ST_START, ST_NEXT, ST_RETX: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      ST_FAIL: begin
        if (status.out_free) state_nxt = ST_RETIRE;
      end
      ST_RETIRE: begin
        state_nxt = status.more_queued ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_NEXT;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.out_free) state_nxt = ST_RETX;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    cmd.emit_sel = EM_PASS;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_DECODE: begin
        cmd.push  = (status.op == OP_SUBMIT) && status.csma_en && !status.full;
        cmd.raise = (status.op == OP_BUSY) && active_ok && !status.raise_fail;
      end
      ST_PASS: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_PASS;
      end
      ST_DROP: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_DROP;
      end
      ST_START: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_START;
      end
      ST_FAIL: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_FAIL;
      end
      ST_RETIRE: begin
        cmd.retire = 1'b1;
      end
      ST_READ: begin
      end
      ST_NEXT: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_NEXT;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_WAIT: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_WAIT;
      end
      ST_RETX: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_RETX;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/ccab_dp.sv -----
// Datapath: registers, handle FIFO, bit-serial remainder and result register.
module ccab_dp
  import ccab_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_packet_handle,
  input  logic [15:0] in_random_value,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_handle_out,
  output logic [15:0] out_wait_ticks,
  output logic        out_last,
  input  cmd_t        cmd,
  output status_t     status
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Configuration
  logic        csma_en_r;
  logic [3:0]  min_exp_r, max_exp_r;
  logic [15:0] unit_time_r;

  // Control state
  logic             tx_active_r, tx_active_nxt;
  logic [3:0]       exponent_r, exponent_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       div_cnt_r;
  logic             out_valid_r;

  // Captured request and working registers
  logic [1:0]            op_r;
  logic [7:0]            handle_r;
  logic [15:0]           rnd_r;
  logic [INTERVAL_W-1:0] interval_r;
  logic [15:0]           rem_r;

  logic [1:0]  out_kind_r;
  logic [7:0]  out_handle_r;
  logic [15:0] out_wait_r;
  logic        out_last_r;

  logic [7:0]       head_handle;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_idx, head_inc;
  logic [4:0]       raised;
  logic             more_queued, out_free, load;
  logic [16:0]      trial;
  logic             trial_ge;
  logic [15:0]      wait_val;
  logic [1:0]       em_kind;
  logic [7:0]       em_handle;
  logic [15:0]      em_wait;
  logic             em_last;

  ccab_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(tail_idx),
    .wdata(handle_r),
    .raddr(head_r),
    .rdata(head_handle)
  );

  // head + count wraps at most once
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                    IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
  assign head_inc = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + IDX_W'(1);

  // One bit wider so exponent 15 still fails
  assign raised      = {1'b0, exponent_r} + 5'd1;
  assign more_queued = count_r > CNT_W'(1);
  assign out_free    = !out_valid_r || !out_stall;
  assign load        = cmd.emit && out_free;

  // Restoring remainder step
  assign trial    = {rem_r, rnd_r[15]};
  assign trial_ge = {14'd0, trial} >= interval_r;

  always_comb begin
    wait_val = rem_r;
    if (interval_r == '0 || rem_r <= SHORT_WAIT_LIMIT) wait_val = '0;
  end

  always_comb begin
    tx_active_nxt = tx_active_r;
    exponent_nxt  = exponent_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    if (cmd.push) count_nxt = count_r + CNT_W'(1);
    if (cmd.raise) exponent_nxt = raised[3:0];
    if (cmd.retire) begin
      tx_active_nxt = 1'b0;
      exponent_nxt  = min_exp_r;
      if (count_r != '0) begin
        head_nxt  = head_inc;
        count_nxt = count_r - CNT_W'(1);
      end
    end
    if (load && (cmd.emit_sel == EM_START || cmd.emit_sel == EM_NEXT)) begin
      tx_active_nxt = 1'b1;
    end
  end

  always_comb begin
    em_kind   = KIND_TX;
    em_handle = handle_r;
    em_wait   = '0;
    em_last   = 1'b1;
    case (cmd.emit_sel)
      EM_PASS, EM_START: begin
        em_kind = KIND_TX;
      end
      EM_DROP: begin
        em_kind = KIND_DROP;
      end
      EM_NEXT, EM_RETX: begin
        em_handle = head_handle;
      end
      EM_FAIL: begin
        em_kind   = KIND_FAIL;
        em_handle = head_handle;
        em_last   = !more_queued;
      end
      EM_WAIT: begin
        em_kind   = KIND_WAIT;
        em_handle = head_handle;
        em_wait   = wait_val;
        em_last   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csma_en_r   <= CSMA_EN_RST;
      min_exp_r   <= MIN_EXP_RST;
      max_exp_r   <= MAX_EXP_RST;
      unit_time_r <= UNIT_TIME_RST;
      tx_active_r <= 1'b0;
      exponent_r  <= MIN_EXP_RST;
      head_r      <= '0;
      count_r     <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_CSMA_EN:   csma_en_r   <= cfg_data[0];
          CFG_MIN_EXP:   min_exp_r   <= cfg_data[3:0];
          CFG_MAX_EXP:   max_exp_r   <= cfg_data[3:0];
          CFG_UNIT_TIME: unit_time_r <= cfg_data;
          default: begin
          end
        endcase
      end
      tx_active_r <= tx_active_nxt;
      exponent_r  <= exponent_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      if (cmd.raise) div_cnt_r <= '0;
      else if (cmd.div_step) div_cnt_r <= div_cnt_r + 4'd1;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_op;
      handle_r <= in_packet_handle;
      rnd_r    <= in_random_value;
    end else if (cmd.div_step) begin
      rnd_r <= {rnd_r[14:0], 1'b0};
    end
    if (cmd.raise) begin
      interval_r <= (INTERVAL_W'(unit_time_r) << raised[3:0]) - INTERVAL_W'(unit_time_r);
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? 16'(trial - interval_r[16:0]) : trial[15:0];
    end
    if (load) begin
      out_kind_r   <= em_kind;
      out_handle_r <= em_handle;
      out_wait_r   <= em_wait;
      out_last_r   <= em_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_handle_out = out_handle_r;
  assign out_wait_ticks = out_wait_r;
  assign out_last       = out_last_r;

  assign status.op          = op_r;
  assign status.csma_en     = csma_en_r;
  assign status.tx_active   = tx_active_r;
  assign status.full        = count_r == CNT_W'(QUEUE_DEPTH);
  assign status.raise_fail  = raised > {1'b0, max_exp_r};
  assign status.more_queued = more_queued;
  assign status.div_last    = div_cnt_r == DIV_CNT_LAST;
  assign status.out_free    = out_free;

endmodule

// ----- rtl/csma_ca_backoff_controller.sv -----
// Top level of the unslotted CSMA-CA backoff controller.
// Takes radio events one request at a time and answers with up to two result
// requests: submit gives one result at most (transmit, or a drop when the
// QUEUE_DEPTH-entry handle FIFO is full), complete retires the head packet and
// may start the next, and channel busy either reports access failure (then
// possibly the next transmit) or gives a backoff wait followed by a
// retransmit. A busy that backs off first runs the bit-serial remainder unit,
// which retires one bit of random_value per cycle. The result register lets
// the next request in while a result still waits under out_stall; the FIFO
// needs no clearing pass after reset. Configuration writes are always taken
// (cfg_ready is tied high) and belong in idle periods.
`include "assert_macros.svh"

module csma_ca_backoff_controller
  import ccab_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Event requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_packet_handle,
  input  logic [15:0] in_random_value,
  // Result requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_handle_out,
  output logic [15:0] out_wait_ticks,
  output logic        out_last
);

  cmd_t    cmd;
  status_t status;

  // Registers are plain flops; no write ever needs to wait
  assign cfg_ready = 1'b1;

  ccab_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .status  (status),
    .in_stall(in_stall),
    .cmd     (cmd)
  );

  ccab_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (in_op),
    .in_packet_handle(in_packet_handle),
    .in_random_value (in_random_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_handle_out  (out_handle_out),
    .out_wait_ticks  (out_wait_ticks),
    .out_last        (out_last),
    .cmd             (cmd),
    .status          (status)
  );

  // Push only with room in the FIFO
  `ASSERT_IMPL(a_push_room, cmd.push, !status.full, "push into full queue")
  // A backoff raise never runs past the maximum exponent
  `ASSERT_IMPL(a_raise_ok, cmd.raise, !status.raise_fail, "raise past max exponent")
  // Retire only a packet that is on air
  `ASSERT_IMPL(a_retire_active, cmd.retire, status.tx_active, "retire while idle")
  // Retire leaves the radio idle until the next start
  `ASSERT_NEXT(a_retire_idle, cmd.retire, !status.tx_active, "tx still active after retire")

endmodule
